// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/sfid_pkg.sv =====
// ----------------------------------------------------------------------------
// sfid_pkg
// Types and constants of the sparse fiber intersection dot product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfid_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int INDEX_BITS    = 16;
  localparam int VALUE_BITS    = 32;
  localparam int SUM_BITS      = 64;
  localparam int ENTRY_BITS    = INDEX_BITS + VALUE_BITS;
  localparam int PTR_BITS      = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_BITS      = $clog2(PENDING_DEPTH + 1);

  localparam logic [1:0] REQ_A = 2'd0;
  localparam logic [1:0] REQ_B = 2'd1;
  localparam logic [1:0] END_A = 2'd2;
  localparam logic [1:0] END_B = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        entry_index;
    logic signed [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic signed [63:0] dot_sum;
    logic               queue_overflow;
  } result_t;

  typedef struct packed {
    logic                         is_end;
    logic                         side;
    logic [INDEX_BITS-1:0]        idx;
    logic signed [VALUE_BITS-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                a_ended;
    logic                b_ended;
  } back_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfid_ram.sv =====
// ----------------------------------------------------------------------------
// sfid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfid_front.sv =====
// ----------------------------------------------------------------------------
// sfid_front
// Accepts request items, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfid_front
  import sfid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t req,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_take
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       do_wr;
  logic       do_rd;

  always_comb begin
    dec.idx = req.entry_index[INDEX_BITS-1:0];
    dec.val = req.entry_value[VALUE_BITS-1:0];
    unique case (req.req_type) inside
      REQ_A, REQ_B: dec.is_end = 1'b0;
      END_A, END_B: dec.is_end = 1'b1;
      default:      dec.is_end = 1'b0;
    endcase
    unique case (req.req_type) inside
      REQ_B, END_B: dec.side = 1'b1;
      REQ_A, END_A: dec.side = 1'b0;
      default:      dec.side = 1'b0;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfid_back.sv =====
// ----------------------------------------------------------------------------
// sfid_back
// Executes commands: pending queue merge, multiply-accumulate, result issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfid_back
  import sfid_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  wire cmd_t         cmd,
  output logic              cmd_take,
  output logic              res_valid,
  output result_t           res,
  input  wire logic         res_ready,
  output back_status_t      status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0]                     state, state_next;
  logic [PTR_BITS-1:0]            head, head_next;
  logic [PTR_BITS-1:0]            tail, tail_next;
  logic [CNT_BITS-1:0]            count, count_next;
  logic                           side, side_next;
  logic                           a_ended, a_ended_next;
  logic                           b_ended, b_ended_next;
  logic [SUM_BITS-1:0]            sum, sum_next;
  logic                           ovf, ovf_next;
  cmd_t                           cur;
  logic                           cur_load;
  logic signed [2*VALUE_BITS-1:0] prod;
  logic                           prod_load;

  logic                           do_push;
  logic                           do_pop;
  logic                           do_clear;
  logic [INDEX_BITS-1:0]          push_idx;
  logic [VALUE_BITS-1:0]          push_val;
  logic                           push_side;
  logic                           we;
  logic [ENTRY_BITS-1:0]          rdata;
  logic [INDEX_BITS-1:0]          front_idx;
  logic signed [VALUE_BITS-1:0]   front_val;
  logic                           own_end;
  logic                           other_end;
  logic                           a_after;
  logic                           b_after;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign front_idx = rdata[ENTRY_BITS-1:VALUE_BITS];
  assign front_val = $signed(rdata[VALUE_BITS-1:0]);
  assign own_end   = cmd.side ? b_ended : a_ended;
  assign other_end = cmd.side ? a_ended : b_ended;
  assign a_after   = a_ended || !cmd.side;
  assign b_after   = b_ended || cmd.side;

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    res_valid  = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_clear   = 1'b0;
    cur_load   = 1'b0;
    prod_load  = 1'b0;
    push_idx   = cmd.idx;
    push_val   = cmd.val;
    push_side  = cmd.side;
    a_ended_next = a_ended;
    b_ended_next = b_ended;
    sum_next     = sum;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_end) begin
            if (a_after && b_after) begin
              if (res_ready) begin
                cmd_take  = 1'b1;
                res_valid = 1'b1;
                do_clear  = 1'b1;
              end
            end else begin
              cmd_take     = 1'b1;
              a_ended_next = a_after;
              b_ended_next = b_after;
            end
          end else begin
            cmd_take = 1'b1;
            if (!own_end && !other_end) begin
              if (count == '0 || side == cmd.side) begin
                do_push = 1'b1;
              end else begin
                cur_load   = 1'b1;
                state_next = ST_CMP;
              end
            end
          end
        end
      end
      ST_CMP: begin
        push_idx  = cur.idx;
        push_val  = cur.val;
        push_side = cur.side;
        if (front_idx < cur.idx) begin
          do_pop = 1'b1;
          if (count == CNT_BITS'(1)) begin
            do_push    = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (front_idx == cur.idx) begin
          do_pop     = 1'b1;
          prod_load  = 1'b1;
          state_next = ST_ACC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ACC: begin
        sum_next   = sum + SUM_BITS'(prod);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    side_next  = side;
    ovf_next   = ovf;
    we         = 1'b0;
    if (do_pop) begin
      head_next = ptr_inc(head);
    end
    if (do_push) begin
      if (count == CNT_BITS'(PENDING_DEPTH) && !do_pop) begin
        ovf_next = 1'b1;
      end else begin
        we        = 1'b1;
        tail_next = ptr_inc(tail);
        side_next = push_side;
      end
    end
    count_next = count + CNT_BITS'(we) - CNT_BITS'(do_pop);
  end

  sfid_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (PENDING_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (we),
    .waddr (tail),
    .wdata ({push_idx, push_val}),
    .raddr (head_next),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur <= cmd;
    end
    if (prod_load) begin
      prod <= front_val * cur.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      state   <= ST_IDLE;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      side    <= 1'b0;
      a_ended <= 1'b0;
      b_ended <= 1'b0;
      sum     <= '0;
      ovf     <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      side    <= side_next;
      a_ended <= a_ended_next;
      b_ended <= b_ended_next;
      sum     <= sum_next;
      ovf     <= ovf_next;
    end
  end

  assign res.dot_sum        = $signed(sum);
  assign res.queue_overflow = ovf;
  assign status.count       = count;
  assign status.a_ended     = a_ended;
  assign status.b_ended     = b_ended;

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_fiber_intersect_dot.sv =====
// Each data entry is queued, ignored, or compared against the pending entries it
// retires, then dropped on a larger front index or accumulated on a match.
// No new command is taken until the compare loop on the pending RAM read port
// and any accumulate have finished; end markers need no compare.
// A result appears in the cycle after the second end marker leaves the command queue.
// Reset (rst, synchronous) empties both queues and clears sum, flags and counts.
// ----------------------------------------------------------------------------
// sparse_fiber_intersect_dot
// Dot product of two sparse fibers by index intersection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sparse_fiber_intersect_dot
  import sfid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  output logic         full,
  input  wire req_t    req,
  output logic         empty,
  input  wire logic    pop,
  output result_t      result
);

  logic         cmd_valid;
  cmd_t         cmd;
  logic         cmd_take;
  logic         res_valid;
  result_t      res;
  logic         res_ready;
  back_status_t status;
  logic         out_valid;

  sfid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sfid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .status    (status)
  );

  assign res_ready = !out_valid || pop;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, status.count <= CNT_BITS'(PENDING_DEPTH))
  `ASSERT_NEXT(a_clear_after_result, clk, rst, res_valid,
               !status.a_ended && !status.b_ended && status.count == '0)
  `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst, res_valid, !out_valid || pop)
  `ASSERT_NEXT(a_accept_queues, clk, rst, push && !full, cmd_valid)

endmodule

`default_nettype wire
